### rtl/btpc_pkg.sv
// Shared constants and the rounding helper for the barometric compensation block.
// No dependencies; used by baro_temp_pressure_compensation.
`default_nettype none

package btpc_pkg;

   // Number of register stages from accepted beat to result register.
   localparam int unsigned PipeDepth = 12;

   // Register indexes on the configuration channel.
   localparam logic [1:0] CSR_CAL_LOW  = 2'd0;
   localparam logic [1:0] CSR_CAL_MID  = 2'd1;
   localparam logic [1:0] CSR_CAL_HIGH = 2'd2;

   // Saturation limits: -40..85 degC in Q16, 0..125000 Pa in Q6.
   localparam logic signed [63:0] TempMin = -64'sd2621440;
   localparam logic signed [63:0] TempMax = 64'sd5570560;
   localparam logic signed [63:0] PresMax = 64'sd8000000;

   // x / 2^s, rounded half away from zero.
   function automatic logic signed [63:0] rnd(input logic signed [63:0] x,
                                              input int unsigned s);
      logic [63:0] mag;
      logic [63:0] half;
      half = 64'd1 << (s - 1);
      mag  = x[63] ? (~x + 64'd1) : x;
      mag  = (mag + half) >> s;
      return x[63] ? signed'(~mag + 64'd1) : signed'(mag);
   endfunction

endpackage

`default_nettype wire

### rtl/baro_temp_pressure_compensation.sv
// Barometric temperature / pressure compensation, twelve-stage pipeline.
// Depends on btpc_pkg (limits, register indexes, rounding helper).
//
// Usage:
//  - csr_*: calibration writes. csr_index 0/1/2 selects bytes 0-7, 8-15,
//    16-20 (low byte first). Index 3 is dropped. csr_ready is always high.
//    Write only while the pipeline is empty.
//  - req_*: one beat carries raw temperature and raw pressure (24 bit each).
//  - rsp_*: one beat per request: temperature in Q16 degC (signed 24 bit),
//    pressure in Q6 Pa (23 bit), both rounded and saturated.
//  An accepted request beat passes stages S1 to S12 before rsp_tvalid.
//  Throughput is one beat per cycle except while the pipeline holds.
//  All stages move together on one enable: a stage advances when the
//  result register is empty or being taken. When rsp_tready is low with
//  a result waiting, the whole pipeline holds and req_tready drops; no
//  beat is lost or repeated. Bubbles ride along as cleared valid bits.
//  Reset clears the valid bits and the calibration bytes (all zero).
`default_nettype none

module baro_temp_pressure_compensation (
   input  wire logic        clock,
   input  wire logic        reset,
   // config write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // [23:0] raw_temperature, [47:24] raw_pressure
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata    // [23:0] temperature_out, [46:24] pressure_out, [47] 0
);

   localparam int unsigned NS = btpc_pkg::PipeDepth;

   // calibration registers
   logic [63:0] cal_low_ff, cal_mid_ff;
   logic [39:0] cal_high_ff;
   logic [167:0] cal;

   assign csr_ready = 1'b1;
   assign cal = {cal_high_ff, cal_mid_ff, cal_low_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_low_ff  <= '0;
         cal_mid_ff  <= '0;
         cal_high_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            btpc_pkg::CSR_CAL_LOW:  cal_low_ff  <= csr_data;
            btpc_pkg::CSR_CAL_MID:  cal_mid_ff  <= csr_data;
            btpc_pkg::CSR_CAL_HIGH: cal_high_ff <= csr_data[39:0];
            default: ;
         endcase
      end
   end

   // coefficients, signedness per datasheet (unsigned ones get a zero sign bit)
   logic [15:0]        t1;
   logic signed [16:0] t2c, p5, p6;
   logic signed [7:0]  t3c, p3, p4, p7, p8, p10, p11;
   logic signed [17:0] p1m, p2m;   // P1 - 2^14, P2 - 2^14
   logic signed [15:0] p9;

   assign t1  = cal[15:0];
   assign t2c = signed'({1'b0, cal[31:16]});
   assign t3c = signed'(cal[39:32]);
   assign p1m = 18'(signed'(cal[55:40])) - 18'sd16384;
   assign p2m = 18'(signed'(cal[71:56])) - 18'sd16384;
   assign p3  = signed'(cal[79:72]);
   assign p4  = signed'(cal[87:80]);
   assign p5  = signed'({1'b0, cal[103:88]});
   assign p6  = signed'({1'b0, cal[119:104]});
   assign p7  = signed'(cal[127:120]);
   assign p8  = signed'(cal[135:128]);
   assign p9  = signed'(cal[151:136]);
   assign p10 = signed'(cal[159:152]);
   assign p11 = signed'(cal[167:160]);

   // handshake: one enable for the whole pipe
   logic [NS-1:0] v_ff;
   logic          en;

   assign en         = !v_ff[NS-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-2:0], req_tvalid};
      end
   end

   // stage-1 inputs
   logic signed [25:0] d;
   logic signed [24:0] rp_in;
   assign d     = signed'({2'b00, req_tdata[23:0]}) - signed'({2'b00, t1, 8'h00});
   assign rp_in = signed'({1'b0, req_tdata[47:24]});

   // raw pressure travels down to stage 9, last read by stage 10
   logic signed [24:0] rp_ff [1:9];
   // temperature travels from stage 3 to the end
   logic signed [23:0] t_ff [3:12];

   logic signed [42:0] pd1_ff;      // d*T2
   logic signed [51:0] dd_ff;       // d*d
   logic signed [63:0] tn_ff;       // t_lin in Q48
   logic signed [47:0] tt4_ff;
   logic signed [40:0] p6t4_ff;
   logic signed [41:0] p2t4_ff;
   logic signed [31:0] p10t4_ff;
   logic signed [48:0] psq4_ff;
   logic signed [31:0] tsq5_ff;
   logic signed [47:0] o6_5_ff, ca5_ff;
   logic signed [33:0] dq5_ff;
   logic signed [56:0] pq5_ff;
   logic signed [55:0] tsqt6_ff;
   logic signed [39:0] p7tsq6_ff, p3tsq6_ff;
   logic signed [58:0] rpdq6_ff;
   logic signed [31:0] qc6_ff;
   logic signed [47:0] off6_ff, ca6_ff;
   logic signed [39:0] tcu7_ff;
   logic signed [47:0] off7_ff, cb7_ff;
   logic signed [39:0] q2a7_ff;
   logic signed [56:0] q3p7_ff;
   logic signed [47:0] p8tcu8_ff, p4tcu8_ff;
   logic signed [63:0] q2p8_ff;
   logic signed [47:0] q3_8_ff, off8_ff, cb8_ff;
   logic signed [47:0] off9_ff, c9_ff, q2_9_ff, q3_9_ff;
   logic signed [52:0] plh10_ff;
   logic signed [45:0] pll10_ff;
   logic signed [47:0] rest10_ff;
   logic signed [47:0] linr11_ff, rest11_ff;
   logic signed [23:0] temp_ff;
   logic [22:0]        pres_ff;

   // combinational pieces with saturation
   logic signed [63:0] tr, acc, pr;
   logic signed [23:0] t_in;
   logic [22:0]        pres_in;
   logic signed [27:0] c_hi;
   logic signed [20:0] c_lo;
   logic signed [63:0] lin;

   always_comb begin
      tr = btpc_pkg::rnd(tn_ff, 32);
      if (tr < btpc_pkg::TempMin)      t_in = btpc_pkg::TempMin[23:0];
      else if (tr > btpc_pkg::TempMax) t_in = btpc_pkg::TempMax[23:0];
      else                             t_in = tr[23:0];

      c_hi = c9_ff[47:20];
      c_lo = signed'({1'b0, c9_ff[19:0]});
      lin  = (64'(plh10_ff) <<< 20) + 64'(pll10_ff);

      acc = 64'(rest11_ff) + 64'(linr11_ff);
      pr  = btpc_pkg::rnd(acc, 10);
      if (pr < 64'sd0)                 pres_in = '0;
      else if (pr > btpc_pkg::PresMax) pres_in = btpc_pkg::PresMax[22:0];
      else                             pres_in = pr[22:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // S1: temperature products
         pd1_ff   <= 43'(d) * 43'(t2c);
         dd_ff    <= 52'(d) * 52'(d);
         rp_ff[1] <= rp_in;
         // S2: t_lin*2^48 = d*T2*2^18 + d^2*T3
         tn_ff    <= (64'(pd1_ff) <<< 18) + 64'(dd_ff) * 64'(t3c);
         rp_ff[2] <= rp_ff[1];
         // S3: round and clamp temperature
         t_ff[3]  <= t_in;
         rp_ff[3] <= rp_ff[2];
         // S4: products of t and of raw pressure
         tt4_ff   <= 48'(t_ff[3]) * 48'(t_ff[3]);
         p6t4_ff  <= 41'(p6) * 41'(t_ff[3]);
         p2t4_ff  <= 42'(p2m) * 42'(t_ff[3]);
         p10t4_ff <= 32'(p10) * 32'(t_ff[3]);
         psq4_ff  <= 49'(rp_ff[3]) * 49'(rp_ff[3]);
         t_ff[4]  <= t_ff[3];
         rp_ff[4] <= rp_ff[3];
         // S5: t^2 in Q16, first offset and coefficient terms
         tsq5_ff  <= 32'(btpc_pkg::rnd(64'(tt4_ff), 16));
         o6_5_ff  <= 48'(btpc_pkg::rnd(64'(p6t4_ff), 6));
         ca5_ff   <= 48'((64'(p1m) <<< 20) + btpc_pkg::rnd(64'(p2t4_ff), 5));
         dq5_ff   <= (34'(p9) <<< 16) + 34'(p10t4_ff);
         pq5_ff   <= 57'(psq4_ff) * 57'(p11);
         t_ff[5]  <= t_ff[4];
         rp_ff[5] <= rp_ff[4];
         // S6
         tsqt6_ff  <= 56'(tsq5_ff) * 56'(t_ff[5]);
         p7tsq6_ff <= 40'(p7) * 40'(tsq5_ff);
         p3tsq6_ff <= 40'(p3) * 40'(tsq5_ff);
         rpdq6_ff  <= 59'(rp_ff[5]) * 59'(dq5_ff);
         qc6_ff    <= 32'(btpc_pkg::rnd(64'(pq5_ff), 25));
         off6_ff   <= (48'(p5) <<< 19) + o6_5_ff;
         ca6_ff    <= ca5_ff;
         t_ff[6]   <= t_ff[5];
         rp_ff[6]  <= rp_ff[5];
         // S7: t^3 in Q16
         tcu7_ff  <= 40'(btpc_pkg::rnd(64'(tsqt6_ff), 16));
         off7_ff  <= off6_ff + 48'(btpc_pkg::rnd(64'(p7tsq6_ff), 8));
         cb7_ff   <= ca6_ff + 48'(btpc_pkg::rnd(64'(p3tsq6_ff), 8));
         q2a7_ff  <= 40'(btpc_pkg::rnd(64'(rpdq6_ff), 24));
         q3p7_ff  <= 57'(qc6_ff) * 57'(rp_ff[6]);
         t_ff[7]  <= t_ff[6];
         rp_ff[7] <= rp_ff[6];
         // S8
         p8tcu8_ff <= 48'(p8) * 48'(tcu7_ff);
         p4tcu8_ff <= 48'(p4) * 48'(tcu7_ff);
         q2p8_ff   <= 64'(q2a7_ff) * 64'(rp_ff[7]);
         q3_8_ff   <= 48'(btpc_pkg::rnd(64'(q3p7_ff), 24));
         off8_ff   <= off7_ff;
         cb8_ff    <= cb7_ff;
         t_ff[8]   <= t_ff[7];
         rp_ff[8]  <= rp_ff[7];
         // S9: finish offset and Q40 linear coefficient
         off9_ff  <= off8_ff + 48'(btpc_pkg::rnd(64'(p8tcu8_ff), 15));
         c9_ff    <= cb8_ff + 48'(btpc_pkg::rnd(64'(p4tcu8_ff), 13));
         q2_9_ff  <= 48'(btpc_pkg::rnd(q2p8_ff, 24));
         q3_9_ff  <= q3_8_ff;
         t_ff[9]  <= t_ff[8];
         rp_ff[9] <= rp_ff[8];
         // S10: raw pressure times coefficient, split in two partial products
         plh10_ff  <= 53'(rp_ff[9]) * 53'(c_hi);
         pll10_ff  <= 46'(rp_ff[9]) * 46'(c_lo);
         rest10_ff <= off9_ff + q2_9_ff + q3_9_ff;
         t_ff[10]  <= t_ff[9];
         // S11
         linr11_ff <= 48'(btpc_pkg::rnd(lin, 24));
         rest11_ff <= rest10_ff;
         t_ff[11]  <= t_ff[10];
         // S12: result register
         t_ff[12]  <= t_ff[11];
         pres_ff   <= pres_in;
      end
   end

   assign temp_ff   = t_ff[12];
   assign rsp_tdata = {1'b0, pres_ff, temp_ff};

endmodule

`default_nettype wire
